// ----- hdl/mea_pkg.sv -----
// Package with the types, constants and operation codes of the monomial exponent ALU.
package mea_pkg;

  localparam int NUM_VARS   = 4;
  localparam int FIELD_VARS = 4;
  localparam int ACT_VARS   = (NUM_VARS < FIELD_VARS) ? NUM_VARS : FIELD_VARS;
  localparam int EXP_W      = 16;
  localparam int RES_W      = 17;
  localparam int DEG_W      = 18;
  localparam int DIV_STEPS  = EXP_W;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MOD   = 3'd1,
    OP_EQ    = 3'd2,
    OP_LEX   = 3'd3,
    OP_RLEX  = 3'd4,
    OP_GRLEX = 3'd5,
    OP_RGLEX = 3'd6,
    OP_DIV   = 3'd7
  } op_t;

  typedef struct packed {
    op_t              req_type;
    logic [EXP_W-1:0] a_exp0;
    logic [EXP_W-1:0] a_exp1;
    logic [EXP_W-1:0] a_exp2;
    logic [EXP_W-1:0] a_exp3;
    logic [EXP_W-1:0] b_exp0;
    logic [EXP_W-1:0] b_exp1;
    logic [EXP_W-1:0] b_exp2;
    logic [EXP_W-1:0] b_exp3;
  } in_t;

  typedef struct packed {
    logic [RES_W-1:0] r_exp0;
    logic [RES_W-1:0] r_exp1;
    logic [RES_W-1:0] r_exp2;
    logic [RES_W-1:0] r_exp3;
    logic             test_true;
    logic             div_by_zero;
  } out_t;

  typedef logic [FIELD_VARS-1:0][EXP_W-1:0] vec_t;

  typedef struct packed {
    op_t                   op;
    vec_t                  a;
    vec_t                  b;
    vec_t                  rem;
    logic [FIELD_VARS-1:0] lt;
    logic [FIELD_VARS-1:0] gt;
    logic [DEG_W-1:0]      da;
    logic [DEG_W-1:0]      db;
    logic                  test;
    logic                  dz;
  } pipe_t;

endpackage

// ----- hdl/mea_div_step.sv -----
// One restoring remainder step for every exponent lane.
module mea_div_step import mea_pkg::*; (
  input  logic [FIELD_VARS-1:0] dbit,
  input  vec_t                  b,
  input  vec_t                  rem_in,
  output vec_t                  rem_out
);

  logic [EXP_W:0] t;

  always_comb begin
    t = '0;
    for (int i = 0; i < FIELD_VARS; i++) begin
      t = {rem_in[i], dbit[i]};
      if (t >= {1'b0, b[i]}) begin
        t = t - {1'b0, b[i]};
      end
      rem_out[i] = t[EXP_W-1:0];
    end
  end

endmodule

// ----- hdl/monomial_exponent_alu.sv -----
// Top level of the monomial exponent ALU: sum, remainder and order tests on exponent vectors.
// The block is a pipeline of 18 register stages, an input stage, sixteen remainder stages
// that each resolve one bit of the 16-bit division, and an output register. A new word is
// accepted in every cycle while in_stall is low; the depth is set by the bit-serial remainder,
// and the order tests are worked out in its first two stages. A stalled output lets the
// pipeline keep filling its empty stages before input is stalled.
module monomial_exponent_alu import mea_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  pipe_t s_r   [DIV_STEPS+1];
  pipe_t s_nxt [DIV_STEPS+1];
  logic  v_r   [DIV_STEPS+1];
  logic  en    [DIV_STEPS+2];
  logic  out_valid_r;
  out_t  out_r, out_nxt;

  assign en[DIV_STEPS+1] = !out_valid_r || !out_stall;
  assign in_stall        = !en[0];
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

  always_comb begin
    s_nxt[0]      = '0;
    s_nxt[0].op   = in_data.req_type;
    s_nxt[0].a[0] = in_data.a_exp0;
    s_nxt[0].a[1] = in_data.a_exp1;
    s_nxt[0].a[2] = in_data.a_exp2;
    s_nxt[0].a[3] = in_data.a_exp3;
    s_nxt[0].b[0] = in_data.b_exp0;
    s_nxt[0].b[1] = in_data.b_exp1;
    s_nxt[0].b[2] = in_data.b_exp2;
    s_nxt[0].b[3] = in_data.b_exp3;
  end

  genvar k;
  generate
    for (k = 0; k <= DIV_STEPS; k++) begin : g_stage
      assign en[k] = !v_r[k] || en[k+1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[k-1 < 0 ? 0 : k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          s_r[k] <= s_nxt[k];
        end
      end

      if (k > 0) begin : g_work
        localparam int BIT = EXP_W - k;
        logic [FIELD_VARS-1:0] dbit;
        vec_t                  rem_step;
        logic                  lexf, lexl;

        always_comb begin
          for (int i = 0; i < FIELD_VARS; i++) begin
            dbit[i] = s_r[k-1].a[i][BIT];
          end
        end

        mea_div_step u_step (
          .dbit    (dbit),
          .b       (s_r[k-1].b),
          .rem_in  (s_r[k-1].rem),
          .rem_out (rem_step)
        );

        always_comb begin
          s_nxt[k]     = s_r[k-1];
          s_nxt[k].rem = rem_step;
          lexf = 1'b0;
          lexl = 1'b0;
          if (k == 1) begin
            s_nxt[k].lt = '0;
            s_nxt[k].gt = '0;
            s_nxt[k].da = '0;
            s_nxt[k].db = '0;
            s_nxt[k].dz = 1'b0;
            for (int i = 0; i < ACT_VARS; i++) begin
              s_nxt[k].lt[i] = s_r[k-1].a[i] < s_r[k-1].b[i];
              s_nxt[k].gt[i] = s_r[k-1].a[i] > s_r[k-1].b[i];
              s_nxt[k].da    = s_nxt[k].da + DEG_W'(s_r[k-1].a[i]);
              s_nxt[k].db    = s_nxt[k].db + DEG_W'(s_r[k-1].b[i]);
              if (s_r[k-1].b[i] == '0) begin
                s_nxt[k].dz = 1'b1;
              end
            end
          end
          if (k == 2) begin
            for (int i = ACT_VARS - 1; i >= 0; i--) begin
              if (s_r[k-1].lt[i] || s_r[k-1].gt[i]) begin
                lexf = s_r[k-1].lt[i];
              end
            end
            for (int i = 0; i < ACT_VARS; i++) begin
              if (s_r[k-1].lt[i] || s_r[k-1].gt[i]) begin
                lexl = s_r[k-1].lt[i];
              end
            end
            case (s_r[k-1].op)
              OP_EQ:    s_nxt[k].test = !(|(s_r[k-1].lt | s_r[k-1].gt));
              OP_LEX:   s_nxt[k].test = lexf;
              OP_RLEX:  s_nxt[k].test = lexl;
              OP_GRLEX: s_nxt[k].test = (s_r[k-1].da != s_r[k-1].db) ?
                                        (s_r[k-1].da < s_r[k-1].db) : lexf;
              OP_RGLEX: s_nxt[k].test = (s_r[k-1].da != s_r[k-1].db) ?
                                        (s_r[k-1].da < s_r[k-1].db) : lexl;
              OP_DIV:   s_nxt[k].test = !(|s_r[k-1].gt);
              default:  s_nxt[k].test = 1'b0;
            endcase
            if (s_r[k-1].op != OP_MOD) begin
              s_nxt[k].dz = 1'b0;
            end
          end
        end
      end
    end
  endgenerate

  logic [FIELD_VARS-1:0][RES_W-1:0] res;

  always_comb begin
    res = '0;
    for (int i = 0; i < ACT_VARS; i++) begin
      case (s_r[DIV_STEPS].op)
        OP_ADD:  res[i] = RES_W'(s_r[DIV_STEPS].a[i]) + RES_W'(s_r[DIV_STEPS].b[i]);
        OP_MOD:  res[i] = RES_W'(s_r[DIV_STEPS].rem[i]);
        default: res[i] = '0;
      endcase
    end
    out_nxt.r_exp0      = res[0];
    out_nxt.r_exp1      = res[1];
    out_nxt.r_exp2      = res[2];
    out_nxt.r_exp3      = res[3];
    out_nxt.test_true   = s_r[DIV_STEPS].test;
    out_nxt.div_by_zero = s_r[DIV_STEPS].dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[DIV_STEPS+1]) begin
      out_valid_r <= v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[DIV_STEPS+1]) begin
      out_r <= out_nxt;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && v_r[0]))
    else $error("input stalled while the pipeline has room");

  a_dz_only_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_by_zero) |-> !out_data.test_true)
    else $error("zero divisor flag raised with a test answer");

  a_test_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.test_true) |->
      (out_data.r_exp0 == '0 && out_data.r_exp1 == '0 &&
       out_data.r_exp2 == '0 && out_data.r_exp3 == '0))
    else $error("test answer with nonzero result components");

endmodule
